>>> design/crcp_pkg.sv
// Package for the call/return cycle profiler: opcodes, status codes and sizing
// constants. No dependencies.
package crcp_pkg;
    localparam int TableOrder  = 12;
    localparam int StackDepth  = 32;
    localparam int AddressBits = 48;

    localparam logic [2:0] OP_ENTER      = 3'd0;
    localparam logic [2:0] OP_EXIT       = 3'd1;
    localparam logic [2:0] OP_REGISTER   = 3'd2;
    localparam logic [2:0] OP_UNREGISTER = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
endpackage

>>> design/crcp_front.sv
// Front end: accepts request beats, unpacks fields into a two-entry queue.
// Depends on crcp_pkg.
module crcp_front #(
    parameter int AW = crcp_pkg::AddressBits,
    parameter int DW = 8 * ((3 + AW + 64 + 7) / 8)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [DW-1:0]   s_axis_tdata,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output logic [2:0]      o_q_func,
    output logic [AW-1:0]   o_q_addr,
    output logic [63:0]     o_q_ts
);
    import crcp_pkg::*;
    localparam int EW = 3 + AW + 64;

    logic [EW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign {o_q_ts, o_q_addr, o_q_func} = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= s_axis_tdata[EW-1:0];
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> r_cnt != 2'd2) else $error("push into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
endmodule

>>> design/crcp_back.sv
// Back end: slot table, call stack and result register; sequencer per request.
// Depends on crcp_pkg.
module crcp_back #(
    parameter int TO = crcp_pkg::TableOrder,
    parameter int SD = crcp_pkg::StackDepth,
    parameter int AW = crcp_pkg::AddressBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enable,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  logic [2:0]    i_q_func,
    input  logic [AW-1:0] i_q_addr,
    input  logic [63:0]   i_q_ts,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [63:0]   o_cycles,
    output logic [63:0]   o_hits
);
    import crcp_pkg::*;
    localparam int NS = 1 << TO;
    localparam int SW = $clog2(SD);
    localparam int DPW = $clog2(SD + 1);

    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EXE = 3'd2,
                           S_ADD = 3'd3, S_CLR = 3'd4;

    logic [AW-1:0] m_tag [NS];
    logic [63:0]   m_cyc [NS];
    logic [63:0]   m_hit [NS];
    logic [TO-1:0] m_cslot [SD];
    logic [63:0]   m_cstart [SD];
    logic [1:0]    m_flag [NS];   // {busy, valid}

    logic [2:0]    r_state;
    logic [TO-1:0] r_clr;
    logic [DPW-1:0] r_depth;
    logic [2:0]    r_func;
    logic [AW-1:0] r_addr;
    logic [63:0]   r_ts;
    logic [TO-1:0] r_idx;
    logic [AW-1:0] r_tag_q;
    logic [63:0]   r_cyc_q, r_hit_q, r_start_q, r_sum;
    logic [1:0]    r_flag_q;
    logic [TO-1:0] r_top_slot;
    logic          r_ovalid;
    logic [1:0]    r_status;
    logic [63:0]   r_ocyc, r_ohit;

    logic [SW-1:0] w_top;
    assign w_top    = SW'(r_depth - DPW'(1));
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;
    assign o_cycles = r_ocyc;
    assign o_hits   = r_ohit;

    // memory reads (registered)
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_tag_q   <= m_tag[(r_func == OP_EXIT) ? r_top_slot : r_idx];
            r_cyc_q   <= m_cyc[(r_func == OP_EXIT) ? r_top_slot : r_idx];
            r_hit_q   <= m_hit[(r_func == OP_EXIT) ? r_top_slot : r_idx];
            r_flag_q  <= m_flag[r_idx];
            r_start_q <= m_cstart[w_top];
        end
        if (o_q_pop) begin
            r_func <= i_q_func;
            r_addr <= i_q_addr;
            r_ts   <= i_q_ts;
            r_idx  <= i_q_addr[TO-1:0];
        end
        if (r_state == S_IDLE && r_depth != '0) begin
            r_top_slot <= m_cslot[w_top];
        end
        r_sum <= r_ts - r_start_q;
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            m_flag[r_clr] <= 2'b00;
        end else if (r_state == S_EXE) begin
            case (r_func)
                OP_ENTER: if (i_enable && r_flag_q == 2'b01 && r_depth < DPW'(SD)) begin
                    // push at the current depth
                    m_cslot[SW'(r_depth)]  <= r_idx;
                    m_cstart[SW'(r_depth)] <= r_ts;
                    m_flag[r_idx] <= 2'b11;
                end
                OP_REGISTER: if (!r_flag_q[0]) begin
                    m_tag[r_idx]  <= r_addr;
                    m_cyc[r_idx]  <= '0;
                    m_hit[r_idx]  <= '0;
                    m_flag[r_idx] <= 2'b01;
                end
                OP_UNREGISTER: if (r_flag_q == 2'b01) m_flag[r_idx] <= 2'b00;
                default: ;
            endcase
        end else if (r_state == S_ADD) begin
            m_cyc[r_top_slot]  <= r_cyc_q + r_sum;
            m_hit[r_top_slot]  <= r_hit_q + 64'd1;
            m_flag[r_top_slot] <= 2'b01;
        end
    end

    logic w_exit_ok;
    assign w_exit_ok = i_enable && r_depth != '0 && r_tag_q == r_addr;

    logic [1:0]  n_status;
    logic [63:0] n_ocyc, n_ohit;
    logic        w_add;

    always_comb begin
        n_status = ST_REFUSED;
        n_ocyc   = '0;
        n_ohit   = '0;
        w_add    = 1'b0;
        case (r_func)
            OP_ENTER: if (i_enable && r_flag_q == 2'b01) begin
                n_status = (r_depth < DPW'(SD)) ? ST_DONE : ST_FULL;
            end
            OP_EXIT:       w_add = w_exit_ok;
            OP_REGISTER:   if (!r_flag_q[0]) n_status = ST_DONE;
            OP_UNREGISTER: if (r_flag_q == 2'b01) n_status = ST_DONE;
            OP_READ: if (r_flag_q[0]) begin
                n_status = ST_DONE;
                n_ocyc   = r_cyc_q;
                n_ohit   = r_hit_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_depth  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + TO'(1);
                    if (r_clr == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (r_ovalid && i_ready) r_ovalid <= 1'b0;
                    if (o_q_pop) r_state <= S_RD;
                end
                S_RD: r_state <= S_EXE;
                S_EXE: begin
                    if (w_add) begin
                        r_state <= S_ADD;
                    end else begin
                        r_status <= n_status;
                        r_ocyc   <= n_ocyc;
                        r_ohit   <= n_ohit;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_func == OP_ENTER && n_status == ST_DONE)
                            r_depth <= r_depth + DPW'(1);
                    end
                end
                S_ADD: begin
                    r_status <= ST_DONE;
                    r_ocyc   <= '0;
                    r_ohit   <= '0;
                    r_ovalid <= 1'b1;
                    r_depth  <= r_depth - DPW'(1);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DPW'(SD)) else $error("stack depth overflow");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_RD) else $error("pop without read");
    a_add_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD |=> o_valid && r_status == ST_DONE) else $error("exit lost");
endmodule

>>> design/call_return_cycle_profiler.sv
// Top level of the call/return cycle profiler: enable register, front queue, back end.
// Depends on crcp_pkg, crcp_front, crcp_back.
// Per request the back end pops it, reads (S_RD), executes (S_EXE) and, on a
// successful exit, adds the elapsed time (S_ADD); then it registers the result.
// A new request is taken only once the last result is taken. Reset: synchronous,
// active low; then all 2^TABLE_ORDER slot flags clear before requests are taken.
module call_return_cycle_profiler #(
    parameter int TABLE_ORDER  = crcp_pkg::TableOrder,
    parameter int STACK_DEPTH  = crcp_pkg::StackDepth,
    parameter int ADDRESS_BITS = crcp_pkg::AddressBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // func[2:0], address, timestamp[63:0], zero pad
    input  logic [8*((3+ADDRESS_BITS+64+7)/8)-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status[1:0], cycles_total[63:0], hit_total[63:0], zero pad
    output logic [135:0] m_axis_tdata
);
    import crcp_pkg::*;
    logic r_enable;
    logic w_qv, w_pop;
    logic [2:0] w_func;
    logic [ADDRESS_BITS-1:0] w_addr;
    logic [63:0] w_ts, w_cyc, w_hit;
    logic [1:0] w_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_enable <= 1'b0;
        else if (i_cfg_we) r_enable <= i_cfg_wdata;
    end

    crcp_front #(.AW(ADDRESS_BITS)) u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_func(w_func),
        .o_q_addr(w_addr), .o_q_ts(w_ts));

    crcp_back #(.TO(TABLE_ORDER), .SD(STACK_DEPTH), .AW(ADDRESS_BITS)) u_back (
        .i_clk, .i_rst_n, .i_enable(r_enable), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_func(w_func), .i_q_addr(w_addr), .i_q_ts(w_ts),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_st), .o_cycles(w_cyc), .o_hits(w_hit));

    assign m_axis_tdata = {6'd0, w_hit, w_cyc, w_st};
endmodule

>>> verif/profiler_checker.sv
// Checker for the call/return cycle profiler: watches both streams, predicts
// each response from its own copy of the slot table and call stack. Uses crcp_pkg.
module profiler_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import crcp_pkg::*;

    localparam int SlotCount = 1 << TableOrder;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] cycles;
        logic [63:0] hits;
    } t_response;

    logic [AddressBits-1:0] tag_mem [SlotCount];
    logic                   valid_mem [SlotCount];
    logic                   busy_mem [SlotCount];
    logic [63:0]            cycles_mem [SlotCount];
    logic [63:0]            hits_mem [SlotCount];
    logic [TableOrder-1:0]  stack_slot [StackDepth];
    logic [63:0]            stack_start [StackDepth];
    int                     depth;
    logic                   enabled;
    t_response              expected_q [$];

    assign o_pending = expected_q.size();

    function automatic t_response profile_event(input logic [2:0] op,
                                                input logic [AddressBits-1:0] addr,
                                                input logic [63:0] now);
        t_response r;
        logic [TableOrder-1:0] idx;
        logic [TableOrder-1:0] top_idx;
        r = '{status: ST_REFUSED, cycles: '0, hits: '0};
        idx = addr[TableOrder-1:0];
        case (op)
            OP_ENTER: begin
                if (enabled && valid_mem[idx] && !busy_mem[idx]) begin
                    if (depth >= StackDepth) begin
                        r.status = ST_FULL;
                    end else begin
                        stack_slot[depth] = idx;
                        stack_start[depth] = now;
                        depth++;
                        busy_mem[idx] = 1'b1;
                        r.status = ST_DONE;
                    end
                end
            end
            OP_EXIT: begin
                if (enabled && depth > 0) begin
                    top_idx = stack_slot[depth-1];
                    if (tag_mem[top_idx] == addr) begin
                        cycles_mem[top_idx] += now - stack_start[depth-1];
                        hits_mem[top_idx] += 64'd1;
                        busy_mem[top_idx] = 1'b0;
                        depth--;
                        r.status = ST_DONE;
                    end
                end
            end
            OP_REGISTER: begin
                if (!valid_mem[idx]) begin
                    tag_mem[idx] = addr;
                    cycles_mem[idx] = '0;
                    hits_mem[idx] = '0;
                    busy_mem[idx] = 1'b0;
                    valid_mem[idx] = 1'b1;
                    r.status = ST_DONE;
                end
            end
            OP_UNREGISTER: begin
                if (valid_mem[idx] && !busy_mem[idx]) begin
                    valid_mem[idx] = 1'b0;
                    r.status = ST_DONE;
                end
            end
            OP_READ: begin
                if (valid_mem[idx]) begin
                    r.cycles = cycles_mem[idx];
                    r.hits = hits_mem[idx];
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_response want;
        t_response got;
        if (!i_rst_n) begin
            for (int i = 0; i < SlotCount; i++) begin
                valid_mem[i] <= 1'b0;
                busy_mem[i] <= 1'b0;
            end
            depth <= 0;
            enabled <= 1'b0;
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{status: m_axis_tdata[1:0], cycles: m_axis_tdata[65:2],
                        hits: m_axis_tdata[129:66]};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.cycles !== want.cycles
                            || got.hits !== want.hits) begin
                        $display({"%0t: mismatch expected st=%0d cyc=%0d hit=%0d,",
                                  " actual st=%0d cyc=%0d hit=%0d"},
                                 $time, want.status, want.cycles, want.hits,
                                 got.status, got.cycles, got.hits);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(profile_event(s_axis_tdata[2:0],
                    s_axis_tdata[3 +: AddressBits], s_axis_tdata[3+AddressBits +: 64]));
            if (i_cfg_we)
                enabled = i_cfg_wdata;
        end
    end
endmodule

>>> verif/tb.sv
// Testbench top for call_return_cycle_profiler: clock, reset, stimulus and verdict.
// Depends on crcp_pkg, the block and profiler_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crcp_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic [AddressBits-1:0] addr_pool [16];
    logic [63:0]  clock_now;

    call_return_cycle_profiler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    profiler_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stalls at the falling edge
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // leave tvalid high on return; a drain, or an idle spell in the next send, drops it
    task automatic send_event(input logic [2:0] op, input logic [AddressBits-1:0] addr,
                              input logic [63:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, now, addr, op};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        drain_responses();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly nested call/return sequences on a small set of registered functions
    task automatic run_random(input int count);
        logic [AddressBits-1:0] call_stack [$];
        logic [AddressBits-1:0] a;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            a = addr_pool[$urandom_range(15)];
            clock_now += 64'($urandom_range(500));
            if (pick < 35) begin
                send_event(OP_ENTER, a, clock_now);
                call_stack.push_back(a);
            end else if (pick < 70) begin
                if (call_stack.size() != 0 && $urandom_range(9) != 0)
                    a = call_stack.pop_back();
                send_event(OP_EXIT, a, clock_now);
            end else if (pick < 78) begin
                send_event(OP_REGISTER, a, clock_now);
            end else if (pick < 84) begin
                send_event(OP_UNREGISTER, a, clock_now);
            end else if (pick < 95) begin
                send_event(OP_READ, a, clock_now);
            end else begin
                send_event(3'($urandom_range(7)), AddressBits'({$urandom, $urandom}),
                           {$urandom, $urandom});
            end
            if (call_stack.size() > 40)
                call_stack.delete();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_now = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // disabled: enter/exit ignored; register, read and undefined opcodes at extremes
        send_event(OP_REGISTER, '0, '0);
        send_event(OP_REGISTER, '1, '1);
        send_event(OP_REGISTER, 48'h5a5_0000_0000, '0);
        send_event(OP_ENTER, '0, 64'd10);
        send_event(OP_EXIT, '0, 64'd20);
        send_event(OP_READ, '0, '0);
        send_event(OP_READ, 48'h123, '0);
        send_event(3'd5, '1, '1);
        send_event(3'd7, '0, '0);
        write_enable(1'b1);
        // wrapping elapsed time, tag mismatch on exit, recursion, busy unregister
        send_event(OP_ENTER, '0, 64'hffff_ffff_ffff_fff0);
        send_event(OP_ENTER, 48'h1000, '0);
        send_event(OP_UNREGISTER, '0, '0);
        send_event(OP_EXIT, 48'h1000, 64'd5);
        send_event(OP_EXIT, '0, 64'd16);
        send_event(OP_READ, '0, '0);
        send_event(OP_EXIT, '0, '0);
        send_event(OP_UNREGISTER, '0, '0);
        send_event(OP_UNREGISTER, '0, '0);
        // fill the call stack then overflow it
        for (int i = 0; i < 33; i++)
            send_event(OP_REGISTER, 48'(i + 16), '0);
        for (int i = 0; i < 33; i++)
            send_event(OP_ENTER, 48'(i + 16), 64'(i));
        for (int i = 32; i >= 0; i--)
            send_event(OP_EXIT, 48'(i + 16), 64'(100 + i));
        send_event(OP_READ, 48'd16, '0);

        for (int i = 0; i < 16; i++) begin
            addr_pool[i] = AddressBits'({$urandom, $urandom});
            if (i >= 12)
                addr_pool[i][TableOrder-1:0] = addr_pool[i-4][TableOrder-1:0];
            send_event(OP_REGISTER, addr_pool[i], '0);
        end
        run_random(200);
        send_idle_pct = 86;
        run_random(200);
        // hold off until every response is back
        drain_responses();
        send_idle_pct = 0;
        recv_stall_pct = 86;
        run_random(200);
        write_enable(1'b0);
        send_idle_pct = 23;
        recv_stall_pct = 23;
        run_random(100);
        write_enable(1'b1);
        run_random(150);

        drain_responses();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> call_return_cycle_profiler.f
design/crcp_pkg.sv
design/crcp_front.sv
design/crcp_back.sv
design/call_return_cycle_profiler.sv
verif/profiler_checker.sv
verif/tb.sv
